FILE: src/assert_macros.svh
// Assertion macros shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent implies consequent on the next edge
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/ptl_pkg.sv
`timescale 1ns / 1ps
package ptl_pkg;
	localparam int PoolDepth = 32;
	localparam int SlotW = $clog2(PoolDepth);
	localparam int CntW = $clog2(PoolDepth + 1);

	typedef enum logic [1:0] {
		REQ_INSERT = 2'd0,
		REQ_REMOVE = 2'd1,
		REQ_RUN = 2'd2,
		REQ_NONE = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		ST_INSERTED = 3'd0,
		ST_FULL = 3'd1,
		ST_REMOVED = 3'd2,
		ST_BAD_REMOVE = 3'd3,
		ST_RUN_ENTRY = 3'd4,
		ST_EMPTY = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_INSERT,
		S_REMOVE,
		S_RUN,
		S_RUN_END,
		S_OUT
	} state_t;

	typedef struct packed {
		logic [31:0] prio;
		logic [15:0] handler;
		logic [31:0] context_v;
	} entry_t;

	// one cell's view to the control
	typedef struct packed {
		logic valid;
		logic [SlotW-1:0] slot;
		entry_t data;
	} cell_out_t;

	typedef struct packed {
		logic insert;   // shift right from position ins_pos
		logic [CntW-1:0] ins_pos;
		logic remove;   // shift left from position rem_pos
		logic [CntW-1:0] rem_pos;
		logic [SlotW-1:0] slot;
		entry_t data;
	} cell_ctl_t;
endpackage

FILE: src/ptl_if.sv
`timescale 1ns / 1ps
interface ptl_req_if;
	logic valid;
	logic ready;
	logic [1:0] req_type;
	logic [31:0] task_priority;
	logic [15:0] handler_id;
	logic [31:0] context_tag;
	logic [4:0] slot_index;
	modport source(output valid, req_type, task_priority, handler_id, context_tag,
		slot_index, input ready);
	modport sink(input valid, req_type, task_priority, handler_id, context_tag,
		slot_index, output ready);
endinterface

interface ptl_rsp_if;
	logic valid;
	logic ready;
	logic [2:0] status;
	logic [4:0] out_slot;
	logic [15:0] out_handler;
	logic [31:0] out_context;
	logic [31:0] out_priority;
	logic last;
	modport source(output valid, status, out_slot, out_handler, out_context,
		out_priority, last, input ready);
	modport sink(input valid, status, out_slot, out_handler, out_context,
		out_priority, last, output ready);
endinterface

interface ptl_cfg_if;
	logic valid;
	logic ready;
	logic [5:0] data;
	modport source(output valid, data, input ready);
	modport sink(input valid, data, output ready);
endinterface

FILE: src/ptl_cell.sv
`timescale 1ns / 1ps
// One position of the sorted list. Position i takes from i-1 on insert, from i+1 on remove.
module ptl_cell (
	input logic clk,
	input logic arst_n,
	input logic [ptl_pkg::CntW-1:0] pos,
	input ptl_pkg::cell_ctl_t ctl,
	input ptl_pkg::cell_out_t left,
	input ptl_pkg::cell_out_t right,
	output ptl_pkg::cell_out_t q
);
	logic valid_q;
	logic [ptl_pkg::SlotW-1:0] slot_q;
	ptl_pkg::entry_t data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.insert && pos == ctl.ins_pos) begin
			valid_q <= 1'b1;
		end else if (ctl.insert && pos > ctl.ins_pos) begin
			valid_q <= left.valid;
		end else if (ctl.remove && pos >= ctl.rem_pos) begin
			valid_q <= right.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.insert && pos == ctl.ins_pos) begin
			slot_q <= ctl.slot;
			data_q <= ctl.data;
		end else if (ctl.insert && pos > ctl.ins_pos) begin
			slot_q <= left.slot;
			data_q <= left.data;
		end else if (ctl.remove && pos >= ctl.rem_pos) begin
			slot_q <= right.slot;
			data_q <= right.data;
		end
	end

	assign q = '{valid: valid_q, slot: slot_q, data: data_q};
endmodule

FILE: src/priority_task_list.sv
`timescale 1ns / 1ps
// priority_task_list: priority-sorted pool of task slots.
// Channels: req (sink) carries insert, remove and run-pass items; rsp (source)
// returns result items, last marks the final one of a request; the user, not the block,
// must ensure cfg writes pool_limit (6 bits, reset 32) only while the block is idle.
// The list is a row of cells in sorted order, one slot per cell; a free
// stack of slot numbers hands out slots.
// Insert: the cell row is scanned one cell per cycle for the first higher
// priority, then the row shifts right to make room for the new entry.
// Remove: scan for the slot, then the row shifts left. Requests are taken only when idle.
// Run pass: one cell per cycle unless a result waits at the output, one result
// per cell with nonzero handler (or one EMPTY result), then the pass ends.
// A pool-full insert is answered with FULL from idle; unknown requests get no result.
// Results go through one output register; when rsp.ready is low the block
// holds that result and waits.
// Reset empties the list and refills the free stack at once (flip-flops).
module priority_task_list (
	input logic clk,
	input logic arst_n,
	ptl_req_if.sink req,
	ptl_rsp_if.source rsp,
	ptl_cfg_if.sink cfg
);
	localparam int N = ptl_pkg::PoolDepth;
	localparam int SW = ptl_pkg::SlotW;
	localparam int CW = ptl_pkg::CntW;

	ptl_pkg::state_t state_q, state_d;
	logic [5:0] limit_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] idx_q;
	logic [SW-1:0] free_q [N];
	logic any_q;
	logic [31:0] prio_q;
	logic [15:0] hnd_q;
	logic [31:0] ctx_q;
	logic [SW-1:0] rslot_q;
	ptl_pkg::cell_ctl_t ctl;
	ptl_pkg::cell_out_t cq [N];
	ptl_pkg::cell_out_t cur;
	ptl_pkg::cell_out_t empty_c;

	logic out_v_q, out_last_q;
	logic [2:0] out_st_q;
	logic [SW-1:0] out_slot_q;
	ptl_pkg::entry_t out_data_q;
	logic ret_run_q;

	logic [CW:0] limit_eff;
	assign limit_eff = (limit_q > 6'(N)) ? (CW+1)'(N) : (CW+1)'(limit_q);
	assign empty_c = '0;
	assign cur = cq[idx_q[SW-1:0]];

	genvar g;
	generate
		for (g = 0; g < N; g++) begin : g_cell
			ptl_cell u_cell (
				.clk(clk), .arst_n(arst_n), .pos(CW'(g)), .ctl(ctl),
				.left(g == 0 ? empty_c : cq[(g == 0) ? 0 : g-1]),
				.right(g == N-1 ? empty_c : cq[(g == N-1) ? g : g+1]),
				.q(cq[g])
			);
		end
	endgenerate

	logic at_end;
	assign at_end = (idx_q >= count_q);
	logic out_free;
	assign out_free = !out_v_q || rsp.ready;

	assign req.ready = (state_q == ptl_pkg::S_IDLE) && out_free;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ptl_pkg::S_IDLE;
		else state_q <= state_d;
	end

	logic emit;
	logic [2:0] e_st;
	logic e_last;
	logic [SW-1:0] e_slot;
	ptl_pkg::entry_t e_data;
	logic push_free, pop_free;

	always_comb begin
		state_d = state_q;
		ctl = '0;
		ctl.slot = free_q[count_q[SW-1:0]];
		ctl.data = '{prio: prio_q, handler: hnd_q, context_v: ctx_q};
		ctl.ins_pos = idx_q;
		ctl.rem_pos = idx_q;
		emit = 1'b0;
		e_st = ptl_pkg::ST_INSERTED;
		e_last = 1'b1;
		e_slot = '0;
		e_data = '0;
		push_free = 1'b0;
		pop_free = 1'b0;
		case (state_q)
			ptl_pkg::S_IDLE: begin
				if (req.valid && req.ready) begin
					case (ptl_pkg::req_t'(req.req_type))
						ptl_pkg::REQ_INSERT: begin
							if ((CW+1)'(count_q) >= limit_eff) begin
								emit = 1'b1;
								e_st = ptl_pkg::ST_FULL;
							end else begin
								state_d = ptl_pkg::S_INSERT;
							end
						end
						ptl_pkg::REQ_REMOVE: state_d = ptl_pkg::S_REMOVE;
						ptl_pkg::REQ_RUN: state_d = ptl_pkg::S_RUN;
						default: state_d = ptl_pkg::S_IDLE;
					endcase
				end
			end
			ptl_pkg::S_INSERT: begin
				if (at_end || cur.data.prio > prio_q) begin
					if (out_free) begin
						ctl.insert = 1'b1;
						pop_free = 1'b1;
						emit = 1'b1;
						e_st = ptl_pkg::ST_INSERTED;
						e_slot = ctl.slot;
						e_data = ctl.data;
						state_d = ptl_pkg::S_IDLE;
					end
				end
			end
			ptl_pkg::S_REMOVE: begin
				if (at_end) begin
					if (out_free) begin
						emit = 1'b1;
						e_st = ptl_pkg::ST_BAD_REMOVE;
						e_slot = rslot_q;
						state_d = ptl_pkg::S_IDLE;
					end
				end else if (cur.slot == rslot_q) begin
					if (out_free) begin
						ctl.remove = 1'b1;
						push_free = 1'b1;
						emit = 1'b1;
						e_st = ptl_pkg::ST_REMOVED;
						e_slot = rslot_q;
						e_data = cur.data;
						state_d = ptl_pkg::S_IDLE;
					end
				end
			end
			ptl_pkg::S_RUN: begin
				if (at_end) begin
					state_d = ptl_pkg::S_RUN_END;
				end else if (cur.data.handler != '0) begin
					// hold finished entry until the next one is known
				end
			end
			ptl_pkg::S_RUN_END: begin
				if (out_free) begin
					emit = 1'b1;
					if (any_q) begin
						e_st = ptl_pkg::ST_RUN_ENTRY;
						e_slot = out_slot_q;
						e_data = out_data_q;
					end else begin
						e_st = ptl_pkg::ST_EMPTY;
					end
					state_d = ptl_pkg::S_IDLE;
				end
			end
			default: state_d = ptl_pkg::S_IDLE;
		endcase
	end

	// run pass: a found entry is staged in pend_*; it is emitted (last=0)
	// when the next one is found, and with last=1 at the end of the pass.
	logic [SW-1:0] pend_slot_q;
	ptl_pkg::entry_t pend_data_q;
	logic run_hit;
	assign run_hit = (state_q == ptl_pkg::S_RUN) && !at_end &&
		(cur.data.handler != '0);
	logic run_stall;
	assign run_stall = run_hit && any_q && !out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= 6'(N);
			count_q <= '0;
			idx_q <= '0;
			any_q <= 1'b0;
			out_v_q <= 1'b0;
			ret_run_q <= 1'b0;
			for (int i = 0; i < N; i++) free_q[i] <= SW'(i);
		end else begin
			if (cfg.valid && cfg.ready) limit_q <= cfg.data;
			if (out_v_q && rsp.ready) out_v_q <= 1'b0;
			if (req.valid && req.ready) begin
				idx_q <= '0;
				any_q <= 1'b0;
			end else if (state_q == ptl_pkg::S_INSERT || state_q == ptl_pkg::S_REMOVE) begin
				if (state_d == state_q) idx_q <= idx_q + 1'b1;
			end else if (state_q == ptl_pkg::S_RUN && !at_end && !run_stall) begin
				idx_q <= idx_q + 1'b1;
				if (run_hit) begin
					any_q <= 1'b1;
					if (any_q) begin
						out_v_q <= 1'b1;
						out_st_q <= ptl_pkg::ST_RUN_ENTRY;
						out_last_q <= 1'b0;
						out_slot_q <= pend_slot_q;
						out_data_q <= pend_data_q;
					end
				end
			end
			if (pop_free) count_q <= count_q + 1'b1;
			if (push_free) begin
				count_q <= count_q - 1'b1;
				free_q[SW'(count_q - 1'b1)] <= rslot_q;
			end
			if (emit) begin
				out_v_q <= 1'b1;
				out_st_q <= e_st;
				out_last_q <= e_last;
				out_slot_q <= (state_q == ptl_pkg::S_RUN_END && any_q) ? pend_slot_q : e_slot;
				out_data_q <= (state_q == ptl_pkg::S_RUN_END && any_q) ? pend_data_q : e_data;
			end
			ret_run_q <= (state_q == ptl_pkg::S_RUN);
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			prio_q <= req.task_priority;
			hnd_q <= req.handler_id;
			ctx_q <= req.context_tag;
			rslot_q <= req.slot_index;
		end else if (run_hit && !run_stall) begin
			pend_slot_q <= cur.slot;
			pend_data_q <= cur.data;
		end
	end

	assign rsp.valid = out_v_q;
	assign rsp.status = out_st_q;
	assign rsp.out_slot = out_slot_q;
	assign rsp.out_handler = out_data_q.handler;
	assign rsp.out_context = out_data_q.context_v;
	assign rsp.out_priority = out_data_q.prio;
	assign rsp.last = out_last_q;

	`include "assert_macros.svh"
	`ASSERT_ALWAYS(a_count_lim, clk, arst_n, count_q <= CW'(N), "count overflow")
	`ASSERT_NEXT(a_pop, clk, arst_n, pop_free, count_q == $past(count_q) + 1'b1,
		"insert did not grow list")
	`ASSERT_NEXT(a_stall_hold, clk, arst_n, out_v_q && !rsp.ready && !ret_run_q,
		$stable(out_slot_q) || !out_v_q, "result changed while stalled")
	`ASSERT_ALWAYS(a_busy, clk, arst_n, !(req.ready && state_q != ptl_pkg::S_IDLE),
		"ready while busy")
endmodule

FILE: verif/ptl_tb_if.sv
`timescale 1ns / 1ps
// Channel interfaces are provided with the RTL (src/ptl_if.sv); this file only
// holds the result record shared by the bench.
package ptl_tb_pkg;
	typedef struct packed {
		logic [2:0] status;
		logic [4:0] slot;
		logic [15:0] handler;
		logic [31:0] context_v;
		logic [31:0] prio;
		logic last;
	} task_rsp_t;
endpackage

FILE: verif/priority_task_list_tb.sv
`timescale 1ns / 1ps
module priority_task_list_tb;
	localparam int CycleLimit = 400000;

	logic clk = 0;
	logic arst_n = 0;
	always #5 clk = ~clk;

	ptl_req_if req();
	ptl_rsp_if rsp();
	ptl_cfg_if cfg();

	priority_task_list u_dut (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp), .cfg(cfg));

	// shadow of the task pool
	logic [5:0] lim_q;
	logic [5:0] nxt_q [0:32];
	logic [5:0] prv_q [0:32];
	logic [31:0] pri_q [0:31];
	logic [15:0] hnd_q [0:31];
	logic [31:0] ctx_q [0:31];
	logic used_q [0:31];
	logic [4:0] free_q [0:31];
	int cnt_q;

	ptl_tb_pkg::task_rsp_t pending_rsp [$];
	int errors = 0;
	int send_idle = 38;
	int recv_idle = 74;
	int cycles = 0;

	function automatic ptl_tb_pkg::task_rsp_t mk(logic [2:0] st, logic [4:0] sl,
			logic [15:0] h, logic [31:0] c, logic [31:0] p, logic l);
		ptl_tb_pkg::task_rsp_t r;
		r.status = st; r.slot = sl; r.handler = h; r.context_v = c; r.prio = p; r.last = l;
		return r;
	endfunction

	function automatic void pool_reset();
		for (int i = 0; i <= 32; i++) begin
			nxt_q[i] = 6'd32;
			prv_q[i] = 6'd32;
		end
		for (int i = 0; i < 32; i++) begin
			used_q[i] = 1'b0;
			free_q[i] = 5'(i);
		end
		cnt_q = 0;
		lim_q = 6'd32;
	endfunction

	function automatic void predict_task(logic [1:0] rt, logic [31:0] p, logic [15:0] h,
			logic [31:0] c, logic [4:0] s);
		int lim, sl, cur, bf, n;
		ptl_tb_pkg::task_rsp_t r;
		if (rt == ptl_pkg::REQ_INSERT) begin
			lim = (lim_q > 6'd32) ? 32 : int'(lim_q);
			if (cnt_q >= lim) begin
				pending_rsp.push_back(mk(ptl_pkg::ST_FULL, 5'd0, 16'd0, 32'd0, 32'd0, 1'b1));
				return;
			end
			sl = free_q[cnt_q];
			cnt_q++;
			pri_q[sl] = p; hnd_q[sl] = h; ctx_q[sl] = c; used_q[sl] = 1'b1;
			bf = 32;
			cur = nxt_q[32];
			for (int k = 0; k < 32 && cur != 32; k++) begin
				if (pri_q[cur] > p) begin
					bf = cur;
					break;
				end
				cur = nxt_q[cur];
			end
			prv_q[sl] = prv_q[bf];
			nxt_q[sl] = 6'(bf);
			nxt_q[prv_q[bf]] = 6'(sl);
			prv_q[bf] = 6'(sl);
			pending_rsp.push_back(mk(ptl_pkg::ST_INSERTED, 5'(sl), h, c, p, 1'b1));
		end else if (rt == ptl_pkg::REQ_REMOVE) begin
			if (!used_q[s] || cnt_q == 0) begin
				pending_rsp.push_back(mk(ptl_pkg::ST_BAD_REMOVE, s, 16'd0, 32'd0, 32'd0, 1'b1));
				return;
			end
			nxt_q[prv_q[s]] = nxt_q[s];
			prv_q[nxt_q[s]] = prv_q[s];
			nxt_q[s] = 6'd32; prv_q[s] = 6'd32;
			used_q[s] = 1'b0;
			cnt_q--;
			free_q[cnt_q] = s;
			pending_rsp.push_back(mk(ptl_pkg::ST_REMOVED, s, hnd_q[s], ctx_q[s], pri_q[s], 1'b1));
		end else if (rt == ptl_pkg::REQ_RUN) begin
			n = 0;
			cur = nxt_q[32];
			for (int k = 0; k < 32 && cur != 32; k++) begin
				if (hnd_q[cur] != 0) begin
					pending_rsp.push_back(mk(ptl_pkg::ST_RUN_ENTRY, 5'(cur), hnd_q[cur],
						ctx_q[cur], pri_q[cur], 1'b0));
					n++;
				end
				cur = nxt_q[cur];
			end
			if (n == 0) pending_rsp.push_back(mk(ptl_pkg::ST_EMPTY, 5'd0, 16'd0, 32'd0, 32'd0,
				1'b1));
			else begin
				r = pending_rsp.pop_back();
				r.last = 1'b1;
				pending_rsp.push_back(r);
			end
		end
	endfunction

	// result checker and receiver stalls
	always @(posedge clk) begin
		ptl_tb_pkg::task_rsp_t got, want;
		cycles <= cycles + 1;
		if (arst_n && rsp.valid && rsp.ready) begin
			got = mk(rsp.status, rsp.out_slot, rsp.out_handler, rsp.out_context,
				rsp.out_priority, rsp.last);
			if (pending_rsp.size() == 0) begin
				$display("%0t: expected none actual %h", $time, got);
				errors++;
			end else begin
				want = pending_rsp.pop_front();
				if (got !== want) begin
					$display("%0t: expected %h actual %h", $time, want, got);
					errors++;
				end
			end
		end
		rsp.ready <= ($urandom_range(99) >= recv_idle);
	end

	always @(posedge clk) begin
		if (cycles > CycleLimit) begin
			$display("tb: failure");
			$finish;
		end
	end

	// valid stays high after an accepted item until the next item or an idle cycle
	task automatic send_task(logic [1:0] rt, logic [31:0] p, logic [15:0] h, logic [31:0] c,
			logic [4:0] s);
		while ($urandom_range(99) < send_idle) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid <= 1'b1;
		req.req_type <= rt;
		req.task_priority <= p;
		req.handler_id <= h;
		req.context_tag <= c;
		req.slot_index <= s;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		predict_task(rt, p, h, c, s);
	endtask

	task automatic drain_results();
		req.valid <= 1'b0;
		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_limit(logic [5:0] v);
		drain_results();
		cfg.valid <= 1'b1;
		cfg.data <= v;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		cfg.valid <= 1'b0;
		lim_q = v;
	endtask

	task automatic random_task();
		int pick;
		logic [31:0] p;
		pick = $urandom_range(99);
		p = ($urandom_range(3) == 0) ? $urandom : $urandom_range(7);
		if (pick < 50)
			send_task(ptl_pkg::REQ_INSERT, p, ($urandom_range(4) == 0) ? 16'd0 : 16'($urandom),
				$urandom, 5'($urandom));
		else if (pick < 80)
			send_task(ptl_pkg::REQ_REMOVE, $urandom, 16'($urandom), $urandom, 5'($urandom));
		else if (pick < 95)
			send_task(ptl_pkg::REQ_RUN, $urandom, 16'($urandom), $urandom, 5'($urandom));
		else
			send_task(ptl_pkg::REQ_NONE, $urandom, 16'($urandom), $urandom, 5'($urandom));
	endtask

	typedef struct {
		logic [1:0] rt;
		logic [31:0] p;
		logic [15:0] h;
		logic [31:0] c;
		logic [4:0] s;
		logic known;
		ptl_tb_pkg::task_rsp_t want;
	} dir_row_t;

	dir_row_t dir_rows [] = '{
		'{ptl_pkg::REQ_RUN, 0, 0, 0, 0, 1, '{ptl_pkg::ST_EMPTY, 0, 0, 0, 0, 1}},
		'{ptl_pkg::REQ_REMOVE, 0, 0, 0, 31, 1, '{ptl_pkg::ST_BAD_REMOVE, 31, 0, 0, 0, 1}},
		'{ptl_pkg::REQ_INSERT, 32'hFFFFFFFF, 16'hFFFF, 32'hFFFFFFFF, 0, 1,
			'{ptl_pkg::ST_INSERTED, 0, 16'hFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 1}},
		'{ptl_pkg::REQ_INSERT, 0, 0, 32'h12345678, 0, 0, '0},
		'{ptl_pkg::REQ_INSERT, 5, 16'h0001, 1, 0, 0, '0},
		'{ptl_pkg::REQ_INSERT, 5, 16'h8000, 2, 0, 0, '0},
		'{ptl_pkg::REQ_INSERT, 5, 16'h5555, 32'hAAAAAAAA, 0, 0, '0},
		'{ptl_pkg::REQ_RUN, 0, 0, 0, 0, 0, '0},
		'{ptl_pkg::REQ_NONE, 1, 1, 1, 1, 0, '0},
		'{ptl_pkg::REQ_REMOVE, 0, 0, 0, 1, 0, '0},
		'{ptl_pkg::REQ_REMOVE, 0, 0, 0, 1, 1, '{ptl_pkg::ST_BAD_REMOVE, 1, 0, 0, 0, 1}},
		'{ptl_pkg::REQ_REMOVE, 0, 0, 0, 0, 0, '0},
		'{ptl_pkg::REQ_RUN, 0, 0, 0, 0, 0, '0},
		'{ptl_pkg::REQ_INSERT, 32'h80000000, 16'h00FF, 32'h0F0F0F0F, 0, 0, '0}
	};

	initial begin
		req.valid = 0; req.req_type = 0; req.task_priority = 0; req.handler_id = 0;
		req.context_tag = 0; req.slot_index = 0;
		rsp.ready = 0; cfg.valid = 0; cfg.data = 0;
		pool_reset();
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			send_task(dir_rows[i].rt, dir_rows[i].p, dir_rows[i].h, dir_rows[i].c,
				dir_rows[i].s);
			if (dir_rows[i].known && pending_rsp[$] !== dir_rows[i].want) begin
				$display("%0t: expected %h actual %h", $time, dir_rows[i].want,
					pending_rsp[$]);
				errors++;
			end
		end

		// tiny pool, pool full path
		write_limit(6'd1);
		repeat (4) send_task(ptl_pkg::REQ_INSERT, $urandom, 16'($urandom), $urandom, 5'd0);
		write_limit(6'd0);
		send_task(ptl_pkg::REQ_INSERT, 32'd1, 16'd1, 32'd1, 5'd0);
		write_limit(6'd63);

		for (int ph = 0; ph < 3; ph++) begin
			send_idle = (ph == 0) ? 38 : (ph == 1 ? 74 : 0);
			recv_idle = (ph == 0) ? 74 : (ph == 1 ? 38 : 0);
			for (int i = 0; i < 45; i++) random_task();
			write_limit(ph == 0 ? 6'd32 : 6'($urandom_range(1, 32)));
			// fill to the limit, then a long run pass
			repeat (34) send_task(ptl_pkg::REQ_INSERT, $urandom_range(3), 16'($urandom),
				$urandom, 5'd0);
			send_task(ptl_pkg::REQ_RUN, 32'd0, 16'd0, 32'd0, 5'd0);
			drain_results();
		end

		drain_results();
		if (errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end
endmodule
